[hdl/stf_pkg.sv]
// ----------------------------------------------------------------------------
// stf_pkg
// Types and constants shared by the star triangle feature pipeline.
// ----------------------------------------------------------------------------
package stf_pkg;

    localparam int IdW     = 20;
    localparam int CompW   = 16;
    localparam int AngW    = 16;
    localparam int SqrtSteps   = 29;
    localparam int CordicSteps = 20;
    localparam int WideW   = 58;
    localparam int CordW   = 32;
    localparam int ZW      = 26;
    // product, clamp, square, root steps, rotate setup, cordic steps, round
    localparam int AngLat  = 3 + SqrtSteps + 1 + CordicSteps + 1;
    localparam logic [AngW-1:0] MaxAngleReset = 16'd5120;
    localparam logic [AngW-1:0] AngleSat      = 16'd46080;

    localparam logic [ZW-1:0] AtanQ16 [0:CordicSteps-1] = '{
        26'd2949120, 26'd1740967, 26'd919879, 26'd466945, 26'd234379,
        26'd117304, 26'd58666, 26'd29335, 26'd14668, 26'd7334,
        26'd3667, 26'd1833, 26'd917, 26'd458, 26'd229,
        26'd115, 26'd57, 26'd29, 26'd14, 26'd7
    };

    typedef struct packed {
        logic [IdW-1:0]          first_id;
        logic [IdW-1:0]          second_id;
        logic [IdW-1:0]          third_id;
        logic signed [CompW-1:0] first_x;
        logic signed [CompW-1:0] first_y;
        logic signed [CompW-1:0] first_z;
        logic signed [CompW-1:0] second_x;
        logic signed [CompW-1:0] second_y;
        logic signed [CompW-1:0] second_z;
        logic signed [CompW-1:0] third_x;
        logic signed [CompW-1:0] third_y;
        logic signed [CompW-1:0] third_z;
    } t_req;

    typedef struct packed {
        logic [IdW-1:0]  id_a;
        logic [IdW-1:0]  id_b;
        logic [IdW-1:0]  id_c;
        logic [AngW-1:0] side_short;
        logic [AngW-1:0] side_middle;
        logic [AngW-1:0] side_long;
    } t_res;

    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
    } t_vec;

endpackage

[hdl/stf_angle.sv]
// ----------------------------------------------------------------------------
// stf_angle
// Pipelined angle between two Q1.14 unit vectors: dot product, clamp,
// bit-per-stage square root and 20-step CORDIC arctangent, Q8.8 degrees out.
// ----------------------------------------------------------------------------
module stf_angle
    import stf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  t_vec            i_a,
    input  t_vec            i_b,
    output logic [AngW-1:0] o_angle
);

    localparam logic signed [33:0] OneQ28 = 34'sd268435456;
    localparam logic [WideW-1:0]   Two56  = WideW'(1) << 56;

    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [29:0] r_d;
    logic [28:0]        r_ad;
    logic signed [29:0] r_dq;
    logic [WideW-1:0]   r_rem;

    logic [WideW-1:0]   r_n   [0:SqrtSteps];
    logic [WideW-1:0]   r_res [0:SqrtSteps];
    logic signed [29:0] r_ds  [0:SqrtSteps];

    logic signed [CordW-1:0] r_x [0:CordicSteps];
    logic signed [CordW-1:0] r_y [0:CordicSteps];
    logic signed [ZW-1:0]    r_z [0:CordicSteps];

    logic signed [33:0] sum;
    logic signed [29:0] n_d;

    always_comb begin
        sum = 34'(r_px) + 34'(r_py) + 34'(r_pz);
        if (sum > OneQ28) begin
            n_d = 30'(OneQ28);
        end else if (sum < -OneQ28) begin
            n_d = 30'(-OneQ28);
        end else begin
            n_d = 30'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= 32'(i_a.x * i_b.x);
            r_py  <= 32'(i_a.y * i_b.y);
            r_pz  <= 32'(i_a.z * i_b.z);
            r_d   <= n_d;
            r_ad  <= n_d[29] ? 29'(-n_d) : 29'(n_d);
            r_dq  <= r_d;
            r_rem <= Two56 - WideW'(r_ad * r_ad);
        end
    end

    always_comb begin
        r_n[0]   = r_rem;
        r_res[0] = '0;
        r_ds[0]  = r_dq;
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        localparam logic [WideW-1:0] Bit = WideW'(1) << (56 - 2 * k);
        logic [WideW-1:0] trial;
        assign trial = r_res[k] + Bit;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ds[k+1] <= r_ds[k];
                if (r_n[k] >= trial) begin
                    r_n[k+1]   <= r_n[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + Bit;
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    logic signed [CordW-1:0] s_val;
    assign s_val = CordW'(signed'({1'b0, r_res[SqrtSteps][29:0]}));

    // negative cosine starts a quarter turn ahead
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ds[SqrtSteps][29]) begin
                r_x[0] <= s_val;
                r_y[0] <= -CordW'(r_ds[SqrtSteps]);
                r_z[0] <= ZW'(90 * 65536);
            end else begin
                r_x[0] <= CordW'(r_ds[SqrtSteps]);
                r_y[0] <= s_val;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
        logic signed [CordW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][CordW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + AtanQ16[i];
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - AtanQ16[i];
                end
            end
        end
    end

    logic [ZW:0] zr;
    always_comb begin
        if (r_z[CordicSteps][ZW-1]) begin
            zr = '0;
        end else begin
            zr = ({1'b0, r_z[CordicSteps]} + (ZW+1)'(128)) >> 8;
        end
    end

    logic [AngW-1:0] r_ang;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= (zr > (ZW+1)'(AngleSat)) ? AngleSat : zr[AngW-1:0];
        end
    end
    assign o_angle = r_ang;

endmodule

[hdl/star_triangle_feature.sv]
// ----------------------------------------------------------------------------
// star_triangle_feature
// Angular feature of one candidate star triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one triangle request per clock while not stalled and delivers its
// result, if the triangle passes the max_angle filter, at the end of the
// pipeline (the square root and CORDIC stages of the three angle units set the depth). The whole pipeline
// advances together; when the output is held by i_stall the input is stalled.
// Dropped triangles produce no output request.
module star_triangle_feature
    import stf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [AngW-1:0] i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_req            i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output t_res            o_res
);

    logic [AngW-1:0] r_max_angle;
    logic            en;
    logic            r_vld [0:AngLat-1];
    logic [3*IdW-1:0] r_ids [0:AngLat-1];
    logic [AngW-1:0] dij, dki, djk;
    logic            r_out_vld;
    t_res            r_out;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_angle <= MaxAngleReset;
        end else if (i_cfg_we) begin
            r_max_angle <= i_cfg_data;
        end
    end

    stf_angle u_ij (.i_clk, .i_en(en),
        .i_a('{i_req.first_x, i_req.first_y, i_req.first_z}),
        .i_b('{i_req.second_x, i_req.second_y, i_req.second_z}), .o_angle(dij));
    stf_angle u_ki (.i_clk, .i_en(en),
        .i_a('{i_req.first_x, i_req.first_y, i_req.first_z}),
        .i_b('{i_req.third_x, i_req.third_y, i_req.third_z}), .o_angle(dki));
    stf_angle u_jk (.i_clk, .i_en(en),
        .i_a('{i_req.second_x, i_req.second_y, i_req.second_z}),
        .i_b('{i_req.third_x, i_req.third_y, i_req.third_z}), .o_angle(djk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AngLat; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < AngLat; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ids[0] <= {i_req.first_id, i_req.second_id, i_req.third_id};
            for (int k = 1; k < AngLat; k++) r_ids[k] <= r_ids[k-1];
        end
    end

    logic [AngW-1:0] ds [0:2];
    logic [IdW-1:0]  is [0:2];
    logic [AngW-1:0] td;
    logic [IdW-1:0]  ti;
    logic            keep;

    // stable compare-swap network on positions 0-1, 1-2, 0-1
    always_comb begin
        td = '0;
        ti = '0;
        ds[0] = djk; is[0] = r_ids[AngLat-1][3*IdW-1:2*IdW];
        ds[1] = dki; is[1] = r_ids[AngLat-1][2*IdW-1:IdW];
        ds[2] = dij; is[2] = r_ids[AngLat-1][IdW-1:0];
        for (int s = 0; s < 3; s++) begin
            if (s == 1) begin
                if (ds[1] > ds[2]) begin
                    td = ds[1]; ds[1] = ds[2]; ds[2] = td;
                    ti = is[1]; is[1] = is[2]; is[2] = ti;
                end
            end else begin
                if (ds[0] > ds[1]) begin
                    td = ds[0]; ds[0] = ds[1]; ds[1] = td;
                    ti = is[0]; is[0] = is[1]; is[1] = ti;
                end
            end
        end
        keep = (dij <= r_max_angle) && (dki < r_max_angle) && (djk < r_max_angle);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[AngLat-1] && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= '{is[0], is[1], is[2], ds[0], ds[1], ds[2]};
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

[tb/star_triangle_feature_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_triangle_feature_checker
// Watches both channels of star_triangle_feature, predicts each triangle's
// feature from the request and the current max_angle, and compares results.
// ----------------------------------------------------------------------------
module star_triangle_feature_checker
    import stf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [AngW-1:0] i_cfg_data,
    input  logic            i_valid,
    input  logic            i_stall_in,
    input  t_req            i_req,
    input  logic            i_res_valid,
    input  logic            i_stall_out,
    input  t_res            i_res,
    output int              o_fail_count,
    output int              o_pending
);

    localparam longint OneQ28 = longint'(1) << 28;
    localparam longint AtanTab [0:19] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [AngW-1:0] limit_q88;
    t_res            feature_q[$];

    assign o_pending = feature_q.size();

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bit_v;
        res   = 0;
        bit_v = longint'(1) << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n   = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [AngW-1:0] arc_angle(t_vec a, t_vec b);
        longint d, ad, s, x, y, z, nx, ny;
        d = longint'(a.x) * longint'(b.x) + longint'(a.y) * longint'(b.y)
          + longint'(a.z) * longint'(b.z);
        if (d > OneQ28) d = OneQ28;
        if (d < -OneQ28) d = -OneQ28;
        ad = (d < 0) ? -d : d;
        s  = int_sqrt((longint'(1) << 56) - ad * ad);
        if (d < 0) begin
            x = s; y = -d; z = 90 * 65536;
        end else begin
            x = d; y = s; z = 0;
        end
        for (int i = 0; i < 20; i++) begin
            if (y >= 0) begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z  = z + AtanTab[i];
            end else begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z  = z - AtanTab[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        if (z > 46080) z = 46080;
        return z[AngW-1:0];
    endfunction

    task automatic predict_feature(t_req r);
        t_vec            v1, v2, v3;
        logic [AngW-1:0] d12, d13, d23, ta;
        logic [AngW-1:0] side [3];
        logic [IdW-1:0]  ids [3];
        logic [IdW-1:0]  ti;
        int              p;
        t_res            f;
        v1 = '{r.first_x, r.first_y, r.first_z};
        v2 = '{r.second_x, r.second_y, r.second_z};
        v3 = '{r.third_x, r.third_y, r.third_z};
        d12 = arc_angle(v1, v2);
        if (d12 > limit_q88) return;
        d13 = arc_angle(v1, v3);
        d23 = arc_angle(v2, v3);
        if (!(d13 < limit_q88 && d23 < limit_q88)) return;
        ids[0] = r.first_id;  side[0] = d23;
        ids[1] = r.second_id; side[1] = d13;
        ids[2] = r.third_id;  side[2] = d12;
        for (int i = 0; i < 3; i++) begin
            p = (i == 1) ? 1 : 0;
            if (side[p] > side[p+1]) begin
                ta = side[p]; side[p] = side[p+1]; side[p+1] = ta;
                ti = ids[p];  ids[p]  = ids[p+1];  ids[p+1]  = ti;
            end
        end
        f = '{ids[0], ids[1], ids[2], side[0], side[1], side[2]};
        feature_q.insert(feature_q.size(), f);
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            limit_q88 <= MaxAngleReset;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) limit_q88 <= i_cfg_data;
            if (i_valid && !i_stall_in) predict_feature(i_req);
            if (i_res_valid && !i_stall_out) begin
                if (feature_q.size() == 0) begin
                    $error("unexpected result %p", i_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = feature_q.pop_front();
                    if (e != i_res) begin
                        o_fail_count <= o_fail_count + 1;
                        if (e.id_a != i_res.id_a)
                            $error("id_a exp %0d got %0d", e.id_a, i_res.id_a);
                        if (e.id_b != i_res.id_b)
                            $error("id_b exp %0d got %0d", e.id_b, i_res.id_b);
                        if (e.id_c != i_res.id_c)
                            $error("id_c exp %0d got %0d", e.id_c, i_res.id_c);
                        if (e.side_short != i_res.side_short)
                            $error("side_short exp %0d got %0d",
                                   e.side_short, i_res.side_short);
                        if (e.side_middle != i_res.side_middle)
                            $error("side_middle exp %0d got %0d",
                                   e.side_middle, i_res.side_middle);
                        if (e.side_long != i_res.side_long)
                            $error("side_long exp %0d got %0d",
                                   e.side_long, i_res.side_long);
                    end
                end
            end
        end
    end

endmodule

[tb/star_triangle_feature_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_triangle_feature_tb
// Drives triangle requests and max_angle settings into star_triangle_feature
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module star_triangle_feature_tb;
    import stf_pkg::*;

    localparam int WatchLimit = 20000;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [AngW-1:0] cfg_data;
    logic            req_valid;
    logic            req_stall;
    t_req            req;
    logic            res_valid;
    logic            res_stall;
    t_res            res;
    int              fail_count;
    int              pending;
    bit              hold_long;
    int              idle_cycles;

    star_triangle_feature uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_stall(req_stall), .i_req(req),
        .o_valid(res_valid), .i_stall(res_stall), .o_res(res)
    );

    star_triangle_feature_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_stall_in(req_stall), .i_req(req),
        .i_res_valid(res_valid), .i_stall_out(res_stall), .i_res(res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // unit-ish vector, random direction, occasionally raw or extreme
    function automatic t_vec rand_vec();
        t_vec v;
        real  a, b, c, n;
        if ($urandom_range(0, 19) == 0) begin
            v.x = CompW'($urandom); v.y = CompW'($urandom); v.z = CompW'($urandom);
            return v;
        end
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c) + 1.0e-9;
        v.x = CompW'($rtoi(16384.0 * a / n));
        v.y = CompW'($rtoi(16384.0 * b / n));
        v.z = CompW'($rtoi(16384.0 * c / n));
        return v;
    endfunction

    // vector near base, so triangles often pass the filter
    function automatic t_vec near_vec(t_vec base, int spread);
        t_vec v;
        v.x = CompW'(base.x + $signed($urandom_range(0, 2 * spread)) - spread);
        v.y = CompW'(base.y + $signed($urandom_range(0, 2 * spread)) - spread);
        v.z = CompW'(base.z + $signed($urandom_range(0, 2 * spread)) - spread);
        return v;
    endfunction

    function automatic t_req make_req(t_vec a, t_vec b, t_vec c);
        t_req r;
        r.first_id = IdW'($urandom); r.second_id = IdW'($urandom);
        r.third_id = IdW'($urandom);
        r.first_x = a.x;  r.first_y = a.y;  r.first_z = a.z;
        r.second_x = b.x; r.second_y = b.y; r.second_z = b.z;
        r.third_x = c.x;  r.third_y = c.y;  r.third_z = c.z;
        return r;
    endfunction

    // valid stays high across back-to-back requests
    task automatic send_req(t_req r);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (AngLat + 8) @(posedge clk);
    endtask

    task automatic write_limit(logic [AngW-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(int count);
        t_vec a, b, c;
        int   spread;
        for (int k = 0; k < count; k++) begin
            a = rand_vec();
            spread = ($urandom_range(0, 3) == 0) ? 16384 : $urandom_range(50, 3000);
            if ($urandom_range(0, 9) < 8) begin
                b = near_vec(a, spread);
                c = near_vec(a, spread);
            end else begin
                b = rand_vec();
                c = rand_vec();
            end
            send_req(make_req(a, b, c));
        end
    endtask

    // receiver stalls, with two long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_long) begin
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        hold_long = 1'b1;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
        repeat (3000) @(posedge clk);
        hold_long = 1'b1;
        repeat (150) @(posedge clk);
        hold_long = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_vec ex, ey, ez, nx, zero_v, big_v;
        rst_n = 0; cfg_we = 0; cfg_data = '0; req_valid = 0; req = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ex = '{16'sd16384, 16'sd0, 16'sd0};
        ey = '{16'sd0, 16'sd16384, 16'sd0};
        ez = '{16'sd0, 16'sd0, 16'sd16384};
        nx = '{-16'sd16384, 16'sd0, 16'sd0};
        zero_v = '{16'sd0, 16'sd0, 16'sd0};
        big_v = '{16'sh7fff, 16'sh7fff, -16'sh8000};

        // directed at reset limit: identical stars, tight triangles, orthogonal and extreme vectors
        send_req(make_req(ex, ex, ex));
        send_req(make_req(ex, near_vec(ex, 300), near_vec(ex, 300)));
        send_req('{20'hfffff, 20'h0, 20'h12345, 16'sd16384, 16'sd0, 16'sd0,
                   16'sd16300, 16'sd1500, 16'sd0, 16'sd16200, 16'sd0, 16'sd2400});
        send_req(make_req(ex, ey, ez));
        send_req(make_req(big_v, big_v, big_v));
        drain();

        write_limit(AngleSat);
        send_req(make_req(ex, ey, ez));
        send_req(make_req(ex, nx, ey));
        send_req(make_req(nx, ex, nx));
        send_req(make_req(zero_v, zero_v, zero_v));
        send_req(make_req(big_v, '{-16'sh8000, 16'sh7fff, 16'sh7fff}, ex));
        send_req(make_req(ex, ex, ey));
        send_req(make_req(ey, ez, ey));
        drain();

        write_limit(16'd0);
        send_req(make_req(ex, ex, ex));
        send_req(make_req(zero_v, ex, ey));
        drain();

        write_limit(16'd23040);
        send_req(make_req(ex, ey, ez));
        send_req(make_req(ex, ey, near_vec(ex, 200)));
        drain();

        write_limit(16'd5120);
        random_phase(450);
        // sender waits for every result before going on
        drain();
        write_limit(16'hffff);
        random_phase(250);
        drain();
        write_limit(16'd2560);
        random_phase(350);
        drain();
        write_limit(16'd12800);
        random_phase(280);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
